// ===== sv/rba_pkg.sv =====
package rba_pkg;
  localparam int MAX_ROWS_D    = 16;
  localparam int MAX_COLUMNS_D = 32;
  localparam int MAX_STATES_D  = 64;
  localparam int REWARD_W      = 16;
  localparam int PREFIX_W      = 21;
  localparam int BEST_W        = 25;
  localparam int COST_W        = 10;
  localparam int BUDGET_W      = 7;
  localparam int ROWCNT_W      = 5;
  localparam int COLCNT_W      = 6;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd2;
endpackage

// ===== sv/rba_ram.sv =====
module rba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/rba_ctrl.sv =====
module rba_ctrl import rba_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_D,
  parameter int MAX_COLUMNS = MAX_COLUMNS_D,
  parameter int MAX_STATES  = MAX_STATES_D,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1,
  localparam int PD = MAX_ROWS * MAX_COLUMNS,
  localparam int PA = $clog2(PD) > 0 ? $clog2(PD) : 1,
  localparam int BA = SW + 1,
  localparam int CA = RW + SW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [REWARD_W-1:0] in_reward,
  input  logic                in_last,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [RW-1:0]       out_row,
  output logic [CW-1:0]       out_col,
  output logic [BEST_W-1:0]   out_best,
  output logic [COST_W-1:0]   out_cost,
  output logic                out_last,
  // prefix memory
  output logic                p_we,
  output logic [PA-1:0]       p_waddr,
  output logic [PREFIX_W-1:0] p_wdata,
  output logic [PA-1:0]       p_raddr,
  input  logic [PREFIX_W-1:0] p_rdata,
  // best memory
  output logic                b_we,
  output logic [BA-1:0]       b_waddr,
  output logic [BEST_W-1:0]   b_wdata,
  output logic [BA-1:0]       b_raddr,
  input  logic [BEST_W-1:0]   b_rdata,
  // choice memory
  output logic                c_we,
  output logic [CA-1:0]       c_waddr,
  output logic [CW-1:0]       c_wdata,
  output logic [CA-1:0]       c_raddr,
  input  logic [CW-1:0]       c_rdata
);
  typedef enum logic [3:0] {
    S_LOAD, S_SYNC, S_LRD, S_LWR, S_R0, S_RD, S_CMP, S_WR, S_BT0, S_BT1, S_OUT
  } st_t;

  st_t st_r;
  logic [BUDGET_W-1:0] budget_r;
  logic [ROWCNT_W-1:0] rowcnt_r;
  logic [COLCNT_W-1:0] colcnt_r;
  logic [RW:0]  lr_r, i_r;
  logic [CW:0]  lc_r, j_r;
  logic [PA-1:0] pos_r, walk_r;
  logic         sync_r;
  logic [SW:0]  b_r;
  logic [REWARD_W-1:0] rew_r;
  logic         lst_r;
  logic [BEST_W-1:0] bv_r, best_r;
  logic [CW-1:0] arg_r;
  logic [COST_W-1:0] cost_r;
  logic [SW:0]  bst_r;
  logic [CW-1:0] chosen_r [MAX_ROWS];
  logic [RW:0]  k_r;

  logic [RW:0] rows;
  logic [CW:0] cols;
  logic [SW:0] ns;
  logic [PA:0] cells;
  logic [BUDGET_W-1:0] half;
  always_comb begin
    rows = (rowcnt_r == '0) ? (RW+1)'(1) :
           (32'(rowcnt_r) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rowcnt_r);
    cols = (colcnt_r == '0) ? (CW+1)'(1) :
           (32'(colcnt_r) > MAX_COLUMNS) ? (CW+1)'(MAX_COLUMNS) : (CW+1)'(colcnt_r);
    half = (budget_r >> 1) + BUDGET_W'(1);
    ns = (32'(half) > MAX_STATES) ? (SW+1)'(MAX_STATES) : (SW+1)'(half);
    cells = (PA+1)'(32'(rows) * 32'(cols));
  end

  logic [PA-1:0] prow_base;
  assign prow_base = PA'(32'(i_r) * MAX_COLUMNS);
  logic [PA-1:0] lbase;
  assign lbase = PA'(32'(lr_r) * MAX_COLUMNS);
  logic          ipar, ppar;
  assign ipar = i_r[0];
  assign ppar = ~i_r[0];
  logic [SW:0] bmj;
  assign bmj = b_r - (SW+1)'(j_r);
  logic [SW:0] c0;
  assign c0 = (32'(b_r) < 32'(cols)) ? b_r : (SW+1)'(cols - 1'b1);
  logic [BEST_W-1:0] cand;
  assign cand = b_rdata + BEST_W'(p_rdata);
  // S_CMP reads both memories, valid the cycle after request
  logic rd_first_r;

  assign in_tready = (st_r == S_LOAD) && !sync_r;
  assign out_tvalid = (st_r == S_OUT);
  assign out_row  = RW'(k_r);
  assign out_col  = chosen_r[RW'(k_r)];
  assign out_best = best_r;
  assign out_cost = cost_r;
  assign out_last = (k_r == rows - 1'b1);

  always_comb begin
    p_we = 1'b0; p_waddr = lbase + PA'(lc_r);
    p_wdata = PREFIX_W'(rew_r) + ((lc_r == '0) ? '0 : p_rdata);
    p_raddr = lbase + PA'(lc_r) - PA'(1);
    b_we = 1'b0; b_waddr = {ipar, SW'(b_r)}; b_wdata = bv_r;
    b_raddr = {ppar, SW'(bmj)};
    c_we = 1'b0; c_waddr = CA'(32'(i_r) * MAX_STATES + 32'(b_r)); c_wdata = arg_r;
    c_raddr = CA'(32'(i_r) * MAX_STATES + 32'(bst_r));
    unique case (st_r)
      S_LWR: p_we = 1'b1;
      S_R0: begin
        p_raddr = PA'(c0);
      end
      S_RD, S_CMP: p_raddr = prow_base + PA'(j_r);
      S_WR: begin
        b_we = 1'b1; c_we = 1'b1;
        if (i_r == '0) begin
          b_wdata = BEST_W'(p_rdata); c_wdata = CW'(c0);
        end
      end
      // final row's best sits in its own parity half
      S_BT0: b_raddr = {ipar, SW'(ns - 1'b1)};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      budget_r <= BUDGET_W'(126); rowcnt_r <= ROWCNT_W'(16); colcnt_r <= COLCNT_W'(32);
      lr_r <= '0; lc_r <= '0; pos_r <= '0; sync_r <= 1'b0; rd_first_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BUDGET:  budget_r <= cfg_data[BUDGET_W-1:0];
          REG_ROWS:    rowcnt_r <= cfg_data[ROWCNT_W-1:0];
          REG_COLUMNS: colcnt_r <= cfg_data[COLCNT_W-1:0];
          default: ;
        endcase
      end
      sync_r <= cfg_we || (sync_r && st_r != S_LOAD);
      unique case (st_r)
        S_LOAD: begin
          if (sync_r) begin
            lr_r <= '0; lc_r <= '0; walk_r <= '0; st_r <= S_SYNC;
          end else if (in_tvalid) begin
            rew_r <= in_reward; lst_r <= in_last; st_r <= S_LRD;
          end
        end
        S_SYNC: begin
          // replay the linear load position onto row and column of the new geometry
          if (32'(pos_r) >= 32'(cells)) begin
            pos_r <= '0; st_r <= S_LOAD;
          end else if (walk_r == pos_r) begin
            st_r <= S_LOAD;
          end else begin
            walk_r <= walk_r + 1'b1;
            if (lc_r + 1'b1 >= cols) begin
              lc_r <= '0; lr_r <= lr_r + 1'b1;
            end else lc_r <= lc_r + 1'b1;
          end
        end
        S_LRD: st_r <= S_LWR;
        S_LWR: begin
          if (lst_r) begin
            lr_r <= '0; lc_r <= '0; pos_r <= '0;
            i_r <= '0; b_r <= '0; st_r <= S_R0;
          end else begin
            st_r <= S_LOAD;
            if (32'(pos_r) + 1 >= 32'(cells)) begin
              pos_r <= '0; lr_r <= '0; lc_r <= '0;
            end else begin
              pos_r <= pos_r + 1'b1;
              if (lc_r + 1'b1 >= cols) begin
                lc_r <= '0; lr_r <= lr_r + 1'b1;
              end else lc_r <= lc_r + 1'b1;
            end
          end
        end
        S_R0: st_r <= S_WR;
        S_RD: begin
          j_r <= j_r + 1'b1; rd_first_r <= 1'b1; st_r <= S_CMP;
          bv_r <= '0; arg_r <= '0;
        end
        S_CMP: begin
          // data of request j_r-1 available now
          if (rd_first_r || cand > bv_r) begin
            bv_r <= cand; arg_r <= CW'(j_r - 1'b1);
          end
          rd_first_r <= 1'b0;
          if (j_r < cols && (SW+1)'(j_r) <= b_r) j_r <= j_r + 1'b1;
          else st_r <= S_WR;
        end
        S_WR: begin
          if (b_r + 1'b1 < ns) begin
            b_r <= b_r + 1'b1;
            st_r <= (i_r == '0) ? S_R0 : S_RD; j_r <= '0;
          end else if (i_r + 1'b1 < rows) begin
            i_r <= i_r + 1'b1; b_r <= '0; j_r <= '0; st_r <= S_RD;
          end else begin
            bst_r <= ns - 1'b1; cost_r <= '0; st_r <= S_BT0;
          end
        end
        S_BT0: begin
          st_r <= S_BT1;
        end
        S_BT1: begin
          // best and choice reads issued in S_BT0 land now (best from the last row's parity half)
          chosen_r[RW'(i_r)] <= c_rdata;
          cost_r <= cost_r + COST_W'({c_rdata, 1'b0});
          bst_r <= bst_r - (SW+1)'(c_rdata);
          if (i_r == rows - 1'b1 && bst_r == ns - 1'b1) best_r <= b_rdata;
          if (i_r == '0) begin
            k_r <= '0; st_r <= S_OUT;
          end else begin
            i_r <= i_r - 1'b1; st_r <= S_BT0;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            if (k_r == rows - 1'b1) st_r <= S_LOAD;
            k_r <= k_r + 1'b1;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== sv/row_budget_allocation_dp_top.sv =====
// Grid load: each request runs S_LOAD, S_LRD, S_LWR (prefix read, add, write back in the
// prefix RAM); no new request is taken before the write back. A register write first
// realigns the load position. last_cell starts the DP: row 0 runs S_R0, S_WR per state,
// later rows run S_RD, S_CMP, S_WR per state b, one compare per cycle on the single
// RAM read ports. Backtrack: S_BT0, S_BT1 per row; results stream one per cycle on out_tready.
// Reset (synchronous, rst_n low): budget 126, 16 rows, 32 columns, load position 0.
module row_budget_allocation_dp_top import rba_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_D,
  parameter int MAX_COLUMNS = MAX_COLUMNS_D,
  parameter int MAX_STATES  = MAX_STATES_D
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // reward
  input  logic                 in_tlast,   // last_cell
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,  // row_index, chosen_column, best_total, total_cost
  output logic                 out_tlast   // last_row
);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int PD = MAX_ROWS * MAX_COLUMNS;
  localparam int PA = $clog2(PD) > 0 ? $clog2(PD) : 1;
  localparam int BA = SW + 1;
  localparam int CA = RW + SW;

  logic p_we, b_we, c_we;
  logic [PA-1:0] p_waddr, p_raddr;
  logic [BA-1:0] b_waddr, b_raddr;
  logic [CA-1:0] c_waddr, c_raddr;
  logic [PREFIX_W-1:0] p_wdata, p_rdata;
  logic [BEST_W-1:0] b_wdata, b_rdata, o_best;
  logic [CW-1:0] c_wdata, c_rdata, o_col;
  logic [RW-1:0] o_row;
  logic [COST_W-1:0] o_cost;

  rba_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS), .MAX_STATES(MAX_STATES)) u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_reward(in_tdata), .in_last(in_tlast),
    .out_tvalid, .out_tready, .out_row(o_row), .out_col(o_col), .out_best(o_best),
    .out_cost(o_cost), .out_last(out_tlast),
    .p_we, .p_waddr, .p_wdata, .p_raddr, .p_rdata,
    .b_we, .b_waddr, .b_wdata, .b_raddr, .b_rdata,
    .c_we, .c_waddr, .c_wdata, .c_raddr, .c_rdata
  );

  rba_ram #(.WIDTH(PREFIX_W), .DEPTH(1 << PA)) u_prefix (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata));
  rba_ram #(.WIDTH(BEST_W), .DEPTH(1 << BA)) u_best (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));
  rba_ram #(.WIDTH(CW), .DEPTH(1 << CA)) u_choice (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata));

  assign out_tdata = {4'd0, o_cost, o_best, 5'(o_col), 4'(o_row)};
endmodule

// ===== tb/tb_row_budget_allocation_dp_top.sv =====
`timescale 1ns / 100ps

module tb_row_budget_allocation_dp_top;
  import rba_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_CELLS = 100;

  typedef struct packed {
    logic       last_row;
    logic [9:0] cost;
    logic [24:0] best;
    logic [4:0] col;
    logic [3:0] row;
  } row_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;   // reward
  logic                 in_tlast = 1'b0; // last_cell
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [47:0]          out_tdata;       // row_index, chosen_column, best_total, total_cost
  logic                 out_tlast;       // last_row

  row_budget_allocation_dp_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [BUDGET_W-1:0] cur_budget;
  logic [ROWCNT_W-1:0] cur_rows;
  logic [COLCNT_W-1:0] cur_cols;
  logic [PREFIX_W-1:0] prefix_sum [MAX_ROWS_D][MAX_COLUMNS_D];
  bit                  cell_loaded [MAX_ROWS_D][MAX_COLUMNS_D];
  int                  load_pos;
  row_result_t         pending_rows [$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int random_cells = 0;

  function automatic int rows_eff();
    return (cur_rows < 1) ? 1 : (cur_rows > MAX_ROWS_D) ? MAX_ROWS_D : int'(cur_rows);
  endfunction

  function automatic int cols_eff();
    return (cur_cols < 1) ? 1 : (cur_cols > MAX_COLUMNS_D) ? MAX_COLUMNS_D : int'(cur_cols);
  endfunction

  function automatic int states_eff();
    int n;
    n = int'(cur_budget) / 2 + 1;
    return (n > MAX_STATES_D) ? MAX_STATES_D : n;
  endfunction

  function automatic bit grid_complete();
    for (int r = 0; r < rows_eff(); r++)
      for (int c = 0; c < cols_eff(); c++)
        if (!cell_loaded[r][c]) return 0;
    return 1;
  endfunction

  function automatic void allocate_budget();
    logic [BEST_W-1:0] best [2][MAX_STATES_D];
    logic [4:0]        choice [MAX_ROWS_D][MAX_STATES_D];
    logic [4:0]        picked [MAX_ROWS_D];
    logic [BEST_W-1:0] bv, v, total;
    logic [9:0]        cost;
    int rows, cols, ns, cur, prv, arg, st, c;
    row_result_t res;
    rows = rows_eff();
    cols = cols_eff();
    ns = states_eff();
    for (int b = 0; b < ns; b++) begin
      c = (b < cols) ? b : cols - 1;
      best[0][b] = BEST_W'(prefix_sum[0][c]);
      choice[0][b] = 5'(c);
    end
    for (int i = 1; i < rows; i++) begin
      cur = i & 1;
      prv = (i - 1) & 1;
      for (int b = 0; b < ns; b++) begin
        bv = best[prv][b] + BEST_W'(prefix_sum[i][0]);
        arg = 0;
        for (int j = 1; j < cols && j <= b; j++) begin
          v = best[prv][b-j] + BEST_W'(prefix_sum[i][j]);
          if (v > bv) begin
            bv = v;
            arg = j;
          end
        end
        best[cur][b] = bv;
        choice[i][b] = 5'(arg);
      end
    end
    total = best[(rows - 1) & 1][ns - 1];
    st = ns - 1;
    cost = '0;
    for (int i = rows - 1; i >= 0; i--) begin
      picked[i] = choice[i][st];
      cost = cost + 10'(2 * int'(picked[i]));
      st = st - int'(picked[i]);
    end
    for (int k = 0; k < rows; k++) begin
      res.row = 4'(k);
      res.col = picked[k];
      res.best = total;
      res.cost = cost;
      res.last_row = (k == rows - 1);
      pending_rows.push_back(res);
    end
    load_pos = 0;
  endfunction

  function automatic void load_reward(logic [15:0] reward, logic last_cell);
    int cells, r, c;
    logic [PREFIX_W-1:0] v;
    cells = rows_eff() * cols_eff();
    if (load_pos >= cells) load_pos = 0;
    r = load_pos / cols_eff();
    c = load_pos % cols_eff();
    v = PREFIX_W'(reward);
    if (c != 0) v = v + prefix_sum[r][c-1];
    prefix_sum[r][c] = v;
    cell_loaded[r][c] = 1;
    load_pos++;
    if (load_pos >= cells) load_pos = 0;
    if (last_cell) allocate_budget();
  endfunction

  task automatic report(string what, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0d got %0d at cycle %0d", what, exp_v, got_v, cycles);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BUDGET:  cur_budget = BUDGET_W'(val);
      REG_ROWS:    cur_rows = ROWCNT_W'(val);
      REG_COLUMNS: cur_cols = COLCNT_W'(val);
      default: ;
    endcase
  endtask

  task automatic send_cell(logic [15:0] reward, logic last_cell);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= reward;
    in_tlast <= last_cell;
    do @(posedge clk); while (!in_tready);
    load_reward(reward, last_cell);
  endtask

  // drain all results, then leave the block idle before returning
  task automatic settle();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_reward();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one grid; short sends early last_cell once the grid is defined, long wraps
  task automatic send_grid(int kind);
    int cells, n;
    cells = rows_eff() * cols_eff();
    n = cells;
    if (kind == 1) n = cells + $urandom_range(1, cols_eff() + 2);
    if (kind == 2 && grid_complete() && cells > 1) n = $urandom_range(1, cells - 1);
    for (int k = 0; k < n; k++) send_cell(pick_reward(), k == n - 1);
    settle();
  endtask

  task automatic set_geometry(int budget_v, int rows_v, int cols_v);
    write_reg(REG_BUDGET, CFG_W'(budget_v));
    write_reg(REG_ROWS, CFG_W'(rows_v));
    write_reg(REG_COLUMNS, CFG_W'(cols_v));
  endtask

  task automatic test_single_cell();
    set_geometry(0, 1, 1);
    send_cell(16'hFFFF, 1'b1);
    send_cell(16'h0000, 1'b1);
    settle();
  endtask

  task automatic test_saturation();
    stall_mode = 1;
    set_geometry(127, 0, 0);
    send_cell(16'h8001, 1'b1);
    settle();
    set_geometry(127, 2, 3);
    for (int k = 0; k < 6; k++) send_cell(k[0] ? 16'hFFFF : 16'h0000, k == 5);
    settle();
    set_geometry(5, 3, 40);
    send_grid(0);
    set_geometry(9, 31, 1);
    send_grid(0);
  endtask

  task automatic test_reset_geometry();
    // default budget and columns; fewer rows keep the grid short
    stall_mode = 2;
    write_reg(REG_ROWS, CFG_W'(6));
    send_grid(0);
  endtask

  task automatic test_random_grids();
    while (random_cells < RANDOM_CELLS) begin
      stall_mode = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0)
        set_geometry($urandom_range(0, 127), $urandom_range(0, 31), $urandom_range(0, 63) % 12);
      else
        set_geometry($urandom_range(0, 127), $urandom_range(1, 4), $urandom_range(1, 8));
      send_grid($urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2));
      random_cells += rows_eff() * cols_eff();
    end
  endtask

  always @(posedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (cycles % 7) < 4;
    endcase
  end

  always @(posedge clk) begin
    row_result_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[row_budget_allocation_dp_top] ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        report("unexpected result", 0, out_tdata[3:0]);
      end else begin
        exp_r = pending_rows.pop_front();
        if (out_tdata[3:0] !== exp_r.row) report("row_index", exp_r.row, out_tdata[3:0]);
        if (out_tdata[8:4] !== exp_r.col) report("chosen_column", exp_r.col, out_tdata[8:4]);
        if (out_tdata[33:9] !== exp_r.best) report("best_total", exp_r.best, out_tdata[33:9]);
        if (out_tdata[43:34] !== exp_r.cost) report("total_cost", exp_r.cost, out_tdata[43:34]);
        if (out_tlast !== exp_r.last_row) report("last_row", exp_r.last_row, out_tlast);
      end
    end
  end

  initial begin
    cur_budget = 7'd126;
    cur_rows = 5'd16;
    cur_cols = 6'd32;
    load_pos = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_single_cell();
    test_saturation();
    test_random_grids();
    settle();
    if (errors == 0) begin
      $display("[row_budget_allocation_dp_top] OK");
    end else begin
      $display("[row_budget_allocation_dp_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rba_pkg.sv
sv/rba_ram.sv
sv/rba_ctrl.sv
sv/row_budget_allocation_dp_top.sv
tb/tb_row_budget_allocation_dp_top.sv
